// ===== src/hpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Horner polynomial evaluator.
// No dependencies; imported by every module of the block.
package hpe_pkg;

   localparam int HPE_NUM_COEFFS = 8;   // default number of coefficients used
   localparam int HPE_REG_COUNT  = 8;   // coefficient registers held
   localparam int HPE_ADDR_W     = $clog2(HPE_REG_COUNT);
   localparam int HPE_Q_SHIFT    = 30;  // fraction bits of x

   // Rounding offset: half an LSB of the Q16.16 result inside the Q18.46 product.
   localparam logic signed [63:0] HPE_HALF_LSB = 64'sd1 <<< (HPE_Q_SHIFT - 1);
   localparam logic signed [34:0] HPE_S32_MAX  = 35'sd2147483647;
   localparam logic signed [34:0] HPE_S32_MIN  = -35'sd2147483648;

   // Item between Horner steps: accumulator, point and sticky overflow.
   typedef struct packed {
      logic signed [31:0] acc;
      logic signed [31:0] x;
      logic               ovf;
   } hpe_acc_type;

   // Item after the multiply: full-width product, point and sticky overflow.
   typedef struct packed {
      logic signed [63:0] prod;
      logic signed [31:0] x;
      logic               ovf;
   } hpe_prod_type;

endpackage

// ===== src/hpe_mul_stage.sv =====
`timescale 1ns / 1ps
// Pipeline stage: multiply accumulator by point and register the 64-bit product.
// Depends on hpe_pkg.
module hpe_mul_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hpe_pkg::hpe_acc_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hpe_pkg::hpe_prod_type out_data
);
   import hpe_pkg::*;

   logic         valid_ff, valid_in;
   hpe_prod_type data_ff, data_in;

   // Take a new transaction when empty or when the held one leaves.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in.prod = in_data.acc * in_data.x;
            data_in.x    = in_data.x;
            data_in.ovf  = in_data.ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/hpe_add_stage.sv =====
`timescale 1ns / 1ps
// Pipeline stage: round product to Q16.16, add coefficient, saturate to 32 bits.
// Depends on hpe_pkg.
module hpe_add_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [31:0]    coeff,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hpe_pkg::hpe_prod_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hpe_pkg::hpe_acc_type  out_data
);
   import hpe_pkg::*;

   logic               valid_ff, valid_in;
   hpe_acc_type        data_ff, data_in;
   logic signed [63:0] biased;
   logic signed [33:0] rounded;
   logic signed [34:0] sum;

   assign in_ready = !valid_ff || out_ready;

   // Round to nearest, ties toward +inf: add half LSB, floor by the shift.
   assign biased  = in_data.prod + HPE_HALF_LSB;
   assign rounded = biased[63:HPE_Q_SHIFT];
   assign sum     = 35'(rounded) + 35'(coeff);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in.x = in_data.x;
            if (sum > HPE_S32_MAX) begin
               data_in.acc = HPE_S32_MAX[31:0];
               data_in.ovf = 1'b1;
            end else if (sum < HPE_S32_MIN) begin
               data_in.acc = HPE_S32_MIN[31:0];
               data_in.ovf = 1'b1;
            end else begin
               data_in.acc = sum[31:0];
               data_in.ovf = in_data.ovf;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/horner_polynomial_evaluator_top.sv =====
`timescale 1ns / 1ps
// Top level of the Horner polynomial evaluator: coefficient registers and the step chain.
// Depends on hpe_pkg, hpe_mul_stage and hpe_add_stage.
//
// Evaluates p(x) = sum of coeff_k * x^k by Horner's rule for a stream of points x
// (signed Q2.30), giving a signed Q16.16 value per point plus a flag that is set if
// any step saturated. Each of the NUM_COEFFS Horner steps is two register stages:
// a 32x32 multiply of accumulator by x, then round-to-nearest (ties up), coefficient
// add and saturation. The throughput is one transaction per cycle while rsp_ is not
// stalled. Every stage has its own valid bit and ready, so bubbles collapse and a
// stall on rsp_ holds results without loss. The user must write coefficients through
// the csr_ port only while no transaction is in flight; the block does not enforce it;
// all coefficients reset to zero, and registers above NUM_COEFFS-1 are held but unused.
module horner_polynomial_evaluator_top #(
   parameter int NUM_COEFFS = hpe_pkg::HPE_NUM_COEFFS
) (
   input  logic                           clock,
   input  logic                           reset,
   // input stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // [31:0] point_x
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // [31:0] poly_value
   output logic                           rsp_tuser,   // [0] overflowed
   // coefficient write port
   input  logic                           csr_wen,
   input  logic [hpe_pkg::HPE_ADDR_W-1:0] csr_addr,
   input  logic [31:0]                    csr_wdata
);
   import hpe_pkg::*;

   // Coefficient registers.
   logic signed [31:0] coeff_ff [HPE_REG_COUNT];
   logic signed [31:0] coeff_in [HPE_REG_COUNT];

   always_comb begin
      for (int i = 0; i < HPE_REG_COUNT; i++) begin
         coeff_in[i] = coeff_ff[i];
      end
      if (csr_wen) begin
         coeff_in[csr_addr] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HPE_REG_COUNT; i++) begin
            coeff_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < HPE_REG_COUNT; i++) begin
            coeff_ff[i] <= coeff_in[i];
         end
      end
   end

   // Chain links: acc_* feed step j, prod_* sit between multiply and add of step j.
   logic         acc_valid [NUM_COEFFS+1];
   logic         acc_ready [NUM_COEFFS+1];
   hpe_acc_type  acc_data  [NUM_COEFFS+1];
   logic         prod_valid [NUM_COEFFS];
   logic         prod_ready [NUM_COEFFS];
   hpe_prod_type prod_data  [NUM_COEFFS];

   // Input register: start each point with a zero accumulator and a clear flag.
   logic        in_valid_ff, in_valid_in;
   hpe_acc_type in_data_ff, in_data_in;

   assign req_tready = !in_valid_ff || acc_ready[0];

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         if (req_tvalid) begin
            in_data_in.acc = '0;
            in_data_in.x   = req_tdata;
            in_data_in.ovf = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
   end

   assign acc_valid[0] = in_valid_ff;
   assign acc_data[0]  = in_data_ff;

   // One multiply and one add stage per coefficient, highest index first.
   for (genvar j = 0; j < NUM_COEFFS; j++) begin : g_step
      localparam int CoeffIdx = NUM_COEFFS - 1 - j;

      hpe_mul_stage u_mul (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (acc_valid[j]),
         .in_ready  (acc_ready[j]),
         .in_data   (acc_data[j]),
         .out_valid (prod_valid[j]),
         .out_ready (prod_ready[j]),
         .out_data  (prod_data[j])
      );

      hpe_add_stage u_add (
         .clock     (clock),
         .reset     (reset),
         .coeff     (coeff_ff[CoeffIdx]),
         .in_valid  (prod_valid[j]),
         .in_ready  (prod_ready[j]),
         .in_data   (prod_data[j]),
         .out_valid (acc_valid[j+1]),
         .out_ready (acc_ready[j+1]),
         .out_data  (acc_data[j+1])
      );
   end

   // The last add stage is the output register.
   assign acc_ready[NUM_COEFFS] = rsp_tready;
   assign rsp_tvalid            = acc_valid[NUM_COEFFS];
   assign rsp_tdata             = acc_data[NUM_COEFFS].acc;
   assign rsp_tuser             = acc_data[NUM_COEFFS].ovf;

endmodule

// ===== sim/hpe_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the Horner polynomial evaluator: watches the csr_, req_ and rsp_ ports,
// predicts every polynomial value and compares it with what the block returns.
// Depends on hpe_pkg for widths and rounding constants.
module hpe_result_checker #(
   parameter int NUM_COEFFS = hpe_pkg::HPE_NUM_COEFFS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // [31:0] point_x
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [31:0]                    rsp_tdata,   // [31:0] poly_value
   input  logic                           rsp_tuser,   // [0] overflowed
   input  logic                           csr_wen,
   input  logic [hpe_pkg::HPE_ADDR_W-1:0] csr_addr,
   input  logic [31:0]                    csr_wdata,
   output int                             fault_count,
   output int                             pending_count
);
   import hpe_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic signed [31:0] point;
      logic signed [31:0] value;
      logic               ovf;
   } poly_expect_type;

   logic signed [31:0] coeff_copy [HPE_REG_COUNT];
   poly_expect_type    expected_values [$];

   // Horner chain: round(acc * x) to Q16.16 with ties up, add coefficient, clamp to 32 bits.
   function automatic poly_expect_type horner_value(input logic signed [31:0] point);
      longint          acc;
      longint          prod;
      longint          rounded;
      longint          total;
      poly_expect_type res;
      acc       = 0;
      res.point = point;
      res.ovf   = 1'b0;
      for (int k = NUM_COEFFS - 1; k >= 0; k--) begin
         prod    = acc * longint'(point);
         rounded = (prod + longint'(HPE_HALF_LSB)) >>> HPE_Q_SHIFT;
         total   = rounded + longint'(coeff_copy[k]);
         if (total > longint'(HPE_S32_MAX)) begin
            total   = longint'(HPE_S32_MAX);
            res.ovf = 1'b1;
         end else if (total < longint'(HPE_S32_MIN)) begin
            total   = longint'(HPE_S32_MIN);
            res.ovf = 1'b1;
         end
         acc = total;
      end
      res.value = acc[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      poly_expect_type head;
      if (reset) begin
         expected_values.delete();
         foreach (coeff_copy[i]) coeff_copy[i] = '0;
      end else begin
         if (csr_wen) coeff_copy[csr_addr] = csr_wdata;
         if (req_tvalid && req_tready) expected_values.push_back(horner_value(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result value %h ovf %b", $realtime, rsp_tdata,
                           rsp_tuser);
            end else begin
               head = expected_values.pop_front();
               if (rsp_tdata !== head.value || rsp_tuser !== head.ovf) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("%0t: x=%h expected value %h ovf %b, got value %h ovf %b",
                              $realtime, head.point, head.value, head.ovf, rsp_tdata,
                              rsp_tuser);
               end
            end
         end
      end
      pending_count <= expected_values.size();
   end

endmodule

// ===== sim/horner_polynomial_evaluator_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the Horner polynomial evaluator: clock, reset, stimulus and verdict.
// Depends on hpe_pkg, horner_polynomial_evaluator_top and hpe_result_checker.
module horner_polynomial_evaluator_top_tb;

   import hpe_pkg::*;

   localparam int  NUM_COEFFS      = HPE_NUM_COEFFS;
   localparam int  PIPE_LATENCY    = 1 + 2 * NUM_COEFFS;
   localparam int  PHASE_COUNT     = 10;
   localparam int  ITEMS_PER_PHASE = 85;
   localparam int  HOLD_CYCLES     = 300;
   localparam int  CYCLE_LIMIT     = 200000;

   // Coefficient corner values in Q16.16.
   localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q16_MIN = 32'h8000_0000;
   localparam logic [31:0] Q16_ONE = 32'h0001_0000;
   // Point corner values in Q2.30.
   localparam logic [31:0] X_MAX      = 32'h7FFF_FFFF;
   localparam logic [31:0] X_MIN      = 32'h8000_0000;
   localparam logic [31:0] X_ONE      = 32'h4000_0000;
   localparam logic [31:0] X_NEG_ONE  = 32'hC000_0000;
   localparam logic [31:0] X_HALF     = 32'h2000_0000;
   localparam logic [31:0] X_NEG_HALF = 32'hE000_0000;

   typedef enum {
      COEF_SMALL, COEF_FULL, COEF_ALTERNATE, COEF_ALL_MAX, COEF_ALL_MIN, COEF_LOW_DEGREE
   } coef_profile_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wen    = 1'b0;
   logic [HPE_ADDR_W-1:0] csr_addr   = '0;
   logic [31:0]           csr_wdata  = '0;

   int                    fault_count;
   int                    pending_count;
   int                    cycle_count    = 0;
   int                    send_idle_pct  = 0;
   int                    recv_stall_pct = 0;
   bit                    hold_request   = 1'b0;
   bit                    hold_done      = 1'b0;
   logic [31:0]           coeff_set [HPE_REG_COUNT];
   logic [31:0]           point_list [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   horner_polynomial_evaluator_top #(.NUM_COEFFS(NUM_COEFFS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   hpe_result_checker #(.NUM_COEFFS(NUM_COEFFS)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_wen       (csr_wen),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   // Watchdog: stop a hung run well past the slowest legal schedule.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: random back-pressure; on request hold off once for a long stretch so the
   // pipeline fills and req_tready drops while the sender keeps offering transactions.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Random Q2.30 point: full range, within +/-1.0, tiny values, or a corner value.
   function automatic logic [31:0] pick_point();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(3))
         0: return r;
         1: return {r[31], r[31], r[29:0]};
         2: return {{12{r[31]}}, r[19:0]};
         default: begin
            case (r[2:0])
               3'd0: return X_MAX;
               3'd1: return X_MIN;
               3'd2: return X_ONE;
               3'd3: return X_NEG_ONE;
               3'd4: return X_HALF;
               3'd5: return X_NEG_HALF;
               3'd6: return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   // Fill coeff_set according to a profile; extremes drive saturation both ways.
   task automatic pick_coeffs(input coef_profile_type profile);
      logic [31:0] r;
      int          degree;
      degree = $urandom_range(NUM_COEFFS - 1);
      for (int i = 0; i < HPE_REG_COUNT; i++) begin
         r = $urandom;
         case (profile)
            COEF_SMALL:      coeff_set[i] = {{12{r[31]}}, r[19:0]};
            COEF_FULL:       coeff_set[i] = r;
            COEF_ALTERNATE:  coeff_set[i] = i[0] ? Q16_MIN : Q16_MAX;
            COEF_ALL_MAX:    coeff_set[i] = Q16_MAX;
            COEF_ALL_MIN:    coeff_set[i] = Q16_MIN;
            COEF_LOW_DEGREE: coeff_set[i] = (i > degree) ? '0 : {{8{r[31]}}, r[23:0]};
            default:         coeff_set[i] = '0;
         endcase
      end
   endtask

   // Write every coefficient register, one per cycle; only called with the block idle.
   task automatic load_coeffs();
      for (int i = 0; i < HPE_REG_COUNT; i++) begin
         csr_wen   <= 1'b1;
         csr_addr  <= HPE_ADDR_W'(i);
         csr_wdata <= coeff_set[i];
         @(posedge clock);
      end
      csr_wen <= 1'b0;
   endtask

   // Offer one point; keep tvalid high across back-to-back transactions.
   task automatic offer_point(input logic [31:0] point);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= point;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic offer_list();
      foreach (point_list[i]) offer_point(point_list[i]);
      point_list.delete();
   endtask

   // Drop tvalid and wait until every expected result has been returned.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Coefficients straight out of reset are all zero.
      point_list = '{X_MAX};
      offer_list();
      settle();

      // Low-order polynomial 1 - 2x + 0.5x^2 over the point corners.
      coeff_set = '{Q16_ONE, 32'hFFFE_0000, 32'h0000_8000, '0, '0, '0, '0, '0};
      load_coeffs();
      point_list = '{32'h0, X_ONE, X_NEG_ONE, X_MAX, X_MIN, 32'hFFFF_FFFF, 32'h1, X_HALF};
      offer_list();
      settle();

      // Single-LSB linear term: products land on half an LSB, check ties go up.
      coeff_set = '{'0, 32'h0000_0001, '0, '0, '0, '0, '0, '0};
      load_coeffs();
      point_list = '{X_HALF, X_NEG_HALF, 32'h6000_0000, 32'hA000_0000};
      offer_list();
      settle();

      // Saturate positive and negative.
      pick_coeffs(COEF_ALL_MAX);
      load_coeffs();
      point_list = '{X_ONE, X_NEG_ONE, X_MAX, X_MIN};
      offer_list();
      settle();
      pick_coeffs(COEF_ALL_MIN);
      load_coeffs();
      point_list = '{X_ONE, X_MIN};
      offer_list();
      settle();

      // Random phases: each with its own coefficients and handshake pressure pattern.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         case (ph)
            0, 7:    pick_coeffs(COEF_LOW_DEGREE);
            2, 8:    pick_coeffs(COEF_FULL);
            3:       pick_coeffs(COEF_ALL_MAX);
            5:       pick_coeffs(COEF_ALL_MIN);
            6:       pick_coeffs(COEF_ALTERNATE);
            default: pick_coeffs(COEF_SMALL);
         endcase
         load_coeffs();
         if (ph == 0) hold_request = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) offer_point(pick_point());
         settle();
      end

      // Let anything stray fall out of the pipeline before the verdict.
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (fault_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
